>>> design/tdp_pkg.sv
package tdp_pkg;

    // Datapath width of the tester; the candidate is taken modulo 2**VALUE_WIDTH.
    localparam int VALUE_WIDTH = 32;
    localparam int CNT_W       = $clog2(VALUE_WIDTH);
    localparam int CAND_W      = 32;

    localparam logic [VALUE_WIDTH-1:0] FIRST_DIVISOR = VALUE_WIDTH'(3);
    localparam logic [VALUE_WIDTH-1:0] DIVISOR_STEP  = VALUE_WIDTH'(2);
    localparam logic [VALUE_WIDTH-1:0] SMALLEST_PRIME = VALUE_WIDTH'(2);
    localparam logic [CNT_W-1:0]       LAST_STEP     = CNT_W'(VALUE_WIDTH - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLASSIFY,
        ST_DIVIDE,
        ST_CHECK
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;        // capture candidate, reset divisor
        logic div_start;   // load dividend into the divider
        logic div_step;    // one restoring-division step
        logic next_div;    // advance divisor by two
        logic res_valid;   // publish a result
        logic res_flag;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic below_two;
        logic is_two;
        logic is_even;
        logic div_last;    // current step is the final one
        logic bound_fail;  // divisor exceeds quotient, i.e. d*d > k
        logic rem_zero;
    } t_status;

endpackage

>>> design/tdp_ctrl.sv
module tdp_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  tdp_pkg::t_status i_status,
    output tdp_pkg::t_cmd    o_cmd,
    output logic             o_busy
);
    import tdp_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_CLASSIFY;
                end
            end
            ST_CLASSIFY: begin
                priority if (i_status.below_two) begin
                    o_cmd.res_valid = 1'b1;
                    o_cmd.res_flag  = 1'b0;
                    n_state         = ST_IDLE;
                end else if (i_status.is_two) begin
                    o_cmd.res_valid = 1'b1;
                    o_cmd.res_flag  = 1'b1;
                    n_state         = ST_IDLE;
                end else if (i_status.is_even) begin
                    o_cmd.res_valid = 1'b1;
                    o_cmd.res_flag  = 1'b0;
                    n_state         = ST_IDLE;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = ST_DIVIDE;
                end
            end
            ST_DIVIDE: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                // bound is tested before the remainder, as the loop condition comes first
                priority if (i_status.bound_fail) begin
                    o_cmd.res_valid = 1'b1;
                    o_cmd.res_flag  = 1'b1;
                    n_state         = ST_IDLE;
                end else if (i_status.rem_zero) begin
                    o_cmd.res_valid = 1'b1;
                    o_cmd.res_flag  = 1'b0;
                    n_state         = ST_IDLE;
                end else begin
                    o_cmd.next_div  = 1'b1;
                    o_cmd.div_start = 1'b1;
                    n_state         = ST_DIVIDE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);

endmodule

>>> design/tdp_dpath.sv
module tdp_dpath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [tdp_pkg::CAND_W-1:0]  i_candidate,
    input  tdp_pkg::t_cmd               i_cmd,
    output tdp_pkg::t_status            o_status,
    output logic                        o_valid,
    output logic                        o_prime_flag
);
    import tdp_pkg::*;

    logic [VALUE_WIDTH-1:0] r_k;
    logic [VALUE_WIDTH-1:0] r_d;
    logic [VALUE_WIDTH-1:0] r_rem;
    logic [VALUE_WIDTH-1:0] r_quo;
    logic [CNT_W-1:0]       r_cnt;
    logic                   r_valid;
    logic                   r_flag;

    logic [VALUE_WIDTH:0]   shifted;
    logic [VALUE_WIDTH:0]   trial;
    logic                   q_bit;
    logic [VALUE_WIDTH-1:0] n_rem;

    // restoring division: bring down one dividend bit, subtract if it fits
    assign shifted = {r_rem, r_quo[VALUE_WIDTH-1]};
    assign trial   = shifted - {1'b0, r_d};
    assign q_bit   = ~trial[VALUE_WIDTH];
    assign n_rem   = q_bit ? trial[VALUE_WIDTH-1:0] : shifted[VALUE_WIDTH-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_k <= VALUE_WIDTH'(i_candidate);
            r_d <= FIRST_DIVISOR;
        end else if (i_cmd.next_div) begin
            r_d <= r_d + DIVISOR_STEP;
        end
        if (i_cmd.div_start) begin
            r_rem <= '0;
            r_quo <= r_k;
            r_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[VALUE_WIDTH-2:0], q_bit};
            r_cnt <= r_cnt + 1'b1;
        end
        if (i_cmd.res_valid) begin
            r_flag <= i_cmd.res_flag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.res_valid;
        end
    end

    always_comb begin
        o_status.below_two  = (r_k < SMALLEST_PRIME);
        o_status.is_two     = (r_k == SMALLEST_PRIME);
        o_status.is_even    = ~r_k[0];
        o_status.div_last   = (r_cnt == LAST_STEP);
        o_status.bound_fail = (r_d > r_quo);
        o_status.rem_zero   = (r_rem == '0);
    end

    assign o_valid      = r_valid;
    assign o_prime_flag = r_flag;

endmodule

>>> design/trial_division_primality_test_unit.sv
// Values below 3 and even values are decided without any division; otherwise one division is run
//   per odd divisor tried (up to about 2**(VALUE_WIDTH/2-1) divisors).
// Throughput: one candidate at a time; busy stays high until the result strobe.
// Each divisor costs one bit-serial restoring division (one bit per cycle) plus a check state.
// Reset (synchronous, active low) returns the controller to idle and clears the strobe.
// The result is shown for one cycle on o_valid; the receiver cannot stall it.
module trial_division_primality_test_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    input  logic [tdp_pkg::CAND_W-1:0]  i_candidate,
    output logic                        busy,
    output logic                        o_valid,
    output logic                        o_prime_flag
);
    import tdp_pkg::*;

    t_cmd    cmd;
    t_status status;

    tdp_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    tdp_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_candidate  (i_candidate),
        .i_cmd        (cmd),
        .o_status     (status),
        .o_valid      (o_valid),
        .o_prime_flag (o_prime_flag)
    );

`ifndef SYNTHESIS
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accepted transfer");

    a_result_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result strobe without work in progress");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_publish_ends_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.res_valid |=> !busy)
        else $error("controller still busy after publishing a result");
`endif

endmodule
